// ===== hw/rtl/bgra_to_yuv420_converter_assert.svh =====
// ---------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter assertion macros
// Property shorthands for the converter's port checker.
// ---------------------------------------------------------------------------
`ifndef BGRA_TO_YUV420_CONVERTER_ASSERT_SVH
`define BGRA_TO_YUV420_CONVERTER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define B2Y_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b2y420 check failed");

// next-cycle implication, off while reset is low
`define B2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b2y420 check failed");

`endif

// ===== hw/rtl/b2y420_pkg.sv =====
// ---------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter package
// Beat types, register codes and color constants shared by the design.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b2y420_pkg;

    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int ROW_W             = 12;
    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int SUM_W             = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_ROUND    = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

    // luma weights
    localparam logic [17:0] KY_R = 18'd77;
    localparam logic [17:0] KY_G = 18'd150;
    localparam logic [17:0] KY_B = 18'd29;
    // chroma weights, magnitudes of the negative terms
    localparam logic [17:0] KCB_R = 18'd43;
    localparam logic [17:0] KCB_G = 18'd85;
    localparam logic [17:0] KCR_G = 18'd107;
    localparam logic [17:0] KCR_B = 18'd21;
    localparam logic [17:0] KC_UNIT = 18'd128;
    localparam logic [17:0] Y_BIAS  = 18'd128;
    // rounding plus the 128 offset moved ahead of the shift
    localparam logic [17:0] C_BIAS  = 18'd32896;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_sum_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgra_to_yuv420_converter.sv =====
// ---------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter
// Full-range BT.601 luma per pixel, 2x2 averaged chroma per block.
// ---------------------------------------------------------------------------
// Usage:
//   s_* takes a BGR pixel beat per ready cycle, raster order (alpha dropped).
//   m_* gives one result beat per pixel: luma, and on the pixel that closes
//   a 2x2 block (odd column of an odd row) chroma_valid with cb/cr.
//   frame_end marks the last pixel of the frame.
//   cfg_wr_en/cfg_index/cfg_wr_data write frame_width, frame_height and
//   chroma_avg_round; write them only while the converter is idle.
//   Path: each pixel passes stage 1, stage 2 and the output register.
//   Throughput: one pixel per cycle unless stalled; at most one line store
//   access per cycle (odd columns only: write on even rows, read on odd rows).
//   Reset: counters restart at column 0, row 0, registers return to
//   1920 x 1080 truncating; the line store is not cleared and needs no pass.
//   Stall: when m_ready is low the three stages fill and s_ready drops;
//   everything holds until the result beat is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bgra_to_yuv420_converter #(
    parameter int MAX_WIDTH = b2y420_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire b2y420_pkg::pixel_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output b2y420_pkg::result_t                      m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [b2y420_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [b2y420_pkg::CFG_W-1:0]        cfg_wr_data
);

    localparam int ColW      = $clog2(MAX_WIDTH);
    localparam int ColCmpW   = ($clog2(MAX_WIDTH + 1) > b2y420_pkg::CFG_W) ?
                               $clog2(MAX_WIDTH + 1) : b2y420_pkg::CFG_W;
    localparam int RowCmpW   = b2y420_pkg::CFG_W;
    localparam int LineDepth = (MAX_WIDTH + 1) / 2;
    localparam int AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
    localparam int SumW      = b2y420_pkg::SUM_W;

    // configuration
    logic [b2y420_pkg::CFG_W-1:0] frame_width_reg;
    logic [b2y420_pkg::CFG_W-1:0] frame_height_reg;
    logic                         avg_round_reg;

    // position and held pixel
    logic [ColW-1:0]                column_count_reg, column_count_next;
    logic [b2y420_pkg::ROW_W-1:0]   row_count_reg, row_count_next;
    b2y420_pkg::pixel_t             held_pixel_reg;

    // line store
    b2y420_pkg::pair_sum_t line_mem [LineDepth];
    b2y420_pkg::pair_sum_t line_rd_reg;

    // stage 1
    logic                   s1_valid_reg;
    b2y420_pkg::pixel_t     s1_pixel_reg;
    b2y420_pkg::pair_sum_t  s1_sum_reg;
    logic                   s1_chroma_reg;
    logic                   s1_fend_reg;

    // stage 2
    logic                   s2_valid_reg;
    logic [7:0]             s2_luma_reg, s2_luma_next;
    logic [7:0]             s2_avg_b_reg, s2_avg_b_next;
    logic [7:0]             s2_avg_g_reg, s2_avg_g_next;
    logic [7:0]             s2_avg_r_reg, s2_avg_r_next;
    logic                   s2_chroma_reg;
    logic                   s2_fend_reg;

    // output
    logic                   m_valid_reg;
    b2y420_pkg::result_t    m_data_reg, m_data_next;

    logic accept;
    logic out_load;
    logic s2_load;
    logic s1_load;

    logic [ColCmpW-1:0]     width_eff;
    logic [ColCmpW-1:0]     col_inc;
    logic                   col_last;
    logic [RowCmpW-1:0]     height_eff;
    logic [RowCmpW-1:0]     row_inc;
    logic                   row_last;
    logic                   col_odd;
    logic                   row_odd;
    logic [AddrW-1:0]       line_addr;
    logic                   line_wr;
    logic                   line_rd;
    b2y420_pkg::pair_sum_t  pair_sum;

    logic [9:0]             sum4_b, sum4_g, sum4_r;
    logic [1:0]             rnd;
    logic [17:0]            luma_x;
    logic [17:0]            cb_x, cr_x;

    // handshake
    assign out_load = !m_valid_reg || m_ready;
    assign s2_load  = !s2_valid_reg || out_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_ready  = s1_load;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= b2y420_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= b2y420_pkg::FRAME_HEIGHT_RESET;
            avg_round_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                b2y420_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                b2y420_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                b2y420_pkg::CFG_AVG_ROUND:    avg_round_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // position tracking
    always_comb begin
        if (frame_width_reg == '0) begin
            width_eff = ColCmpW'(1);
        end else if (ColCmpW'(frame_width_reg) > ColCmpW'(MAX_WIDTH)) begin
            width_eff = ColCmpW'(MAX_WIDTH);
        end else begin
            width_eff = ColCmpW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            height_eff = RowCmpW'(1);
        end else if (frame_height_reg > RowCmpW'(b2y420_pkg::MAX_HEIGHT)) begin
            height_eff = RowCmpW'(b2y420_pkg::MAX_HEIGHT);
        end else begin
            height_eff = frame_height_reg;
        end
        col_inc  = ColCmpW'(column_count_reg) + ColCmpW'(1);
        row_inc  = RowCmpW'(row_count_reg) + RowCmpW'(1);
        col_last = (col_inc >= width_eff);
        row_last = (row_inc >= height_eff);

        column_count_next = col_last ? '0 : ColW'(col_inc);
        if (col_last) begin
            row_count_next = row_last ? '0 : b2y420_pkg::ROW_W'(row_inc);
        end else begin
            row_count_next = row_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (accept) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !col_odd) begin
            held_pixel_reg <= s_data;
        end
    end

    // line store access
    assign col_odd   = column_count_reg[0];
    assign row_odd   = row_count_reg[0];
    assign line_addr = AddrW'(column_count_reg >> 1);
    assign line_wr   = accept && col_odd && !row_odd;
    assign line_rd   = accept && col_odd && row_odd;

    always_comb begin
        pair_sum.blue  = SumW'(held_pixel_reg.blue)  + SumW'(s_data.blue);
        pair_sum.green = SumW'(held_pixel_reg.green) + SumW'(s_data.green);
        pair_sum.red   = SumW'(held_pixel_reg.red)   + SumW'(s_data.red);
    end

    always_ff @(posedge aclk) begin
        if (line_wr) begin
            line_mem[line_addr] <= pair_sum;
        end
        if (line_rd) begin
            line_rd_reg <= line_mem[line_addr];
        end
    end

    // stage 1: capture pixel, pair sums and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg  <= s_data;
            s1_sum_reg    <= pair_sum;
            s1_chroma_reg <= col_odd && row_odd;
            s1_fend_reg   <= col_last && row_last;
        end
    end

    // stage 2: luma and block averages
    always_comb begin
        rnd    = avg_round_reg ? 2'd2 : 2'd0;
        sum4_b = 10'(s1_sum_reg.blue)  + 10'(line_rd_reg.blue)  + 10'(rnd);
        sum4_g = 10'(s1_sum_reg.green) + 10'(line_rd_reg.green) + 10'(rnd);
        sum4_r = 10'(s1_sum_reg.red)   + 10'(line_rd_reg.red)   + 10'(rnd);
        s2_avg_b_next = sum4_b[9:2];
        s2_avg_g_next = sum4_g[9:2];
        s2_avg_r_next = sum4_r[9:2];

        luma_x = 18'(s1_pixel_reg.red)   * b2y420_pkg::KY_R
               + 18'(s1_pixel_reg.green) * b2y420_pkg::KY_G
               + 18'(s1_pixel_reg.blue)  * b2y420_pkg::KY_B
               + b2y420_pkg::Y_BIAS;
        s2_luma_next = luma_x[15:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_load) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load && s1_valid_reg) begin
            s2_luma_reg   <= s2_luma_next;
            s2_avg_b_reg  <= s2_avg_b_next;
            s2_avg_g_reg  <= s2_avg_g_next;
            s2_avg_r_reg  <= s2_avg_r_next;
            s2_chroma_reg <= s1_chroma_reg;
            s2_fend_reg   <= s1_fend_reg;
        end
    end

    // output stage: chroma matrix and clamp
    always_comb begin
        cb_x = 18'(s2_avg_b_reg) * b2y420_pkg::KC_UNIT + b2y420_pkg::C_BIAS
             - 18'(s2_avg_r_reg) * b2y420_pkg::KCB_R
             - 18'(s2_avg_g_reg) * b2y420_pkg::KCB_G;
        cr_x = 18'(s2_avg_r_reg) * b2y420_pkg::KC_UNIT + b2y420_pkg::C_BIAS
             - 18'(s2_avg_g_reg) * b2y420_pkg::KCR_G
             - 18'(s2_avg_b_reg) * b2y420_pkg::KCR_B;

        m_data_next.luma         = s2_luma_reg;
        m_data_next.chroma_valid = s2_chroma_reg;
        m_data_next.frame_end    = s2_fend_reg;
        if (!s2_chroma_reg) begin
            m_data_next.cb = '0;
            m_data_next.cr = '0;
        end else begin
            m_data_next.cb = cb_x[16] ? 8'hFF : cb_x[15:8];
            m_data_next.cr = cr_x[16] ? 8'hFF : cr_x[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && s2_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b2y420_checker.sv =====
// ---------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter port checker
// Watches the result channel of the converter; bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bgra_to_yuv420_converter_assert.svh"

module b2y420_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire b2y420_pkg::result_t m_data
);

    // hold a stalled beat
    `B2Y_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // chroma fields are zero unless a block completes
    `B2Y_ASSERT_IMPLY(a_chroma_zero, aclk, aresetn, m_valid && !m_data.chroma_valid, (m_data.cb == 8'd0) && (m_data.cr == 8'd0))

    // drop valid only after the beat was taken
    `B2Y_ASSERT_IMPLY(a_out_drop, aclk, aresetn, $fell(m_valid) && $past(aresetn), $past(m_ready))

endmodule

bind bgra_to_yuv420_converter b2y420_checker u_b2y420_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// BGRA to YUV 4:2:0 converter testbench
// Drives pixel beats with random gaps against a randomly stalled result
// side. An in-bench predictor tracks the column and row counters, the held
// pixel and the pair-sum line store, and gives the luma, chroma and
// frame_end of every unpinned beat. A directed table (extremes, clamping,
// odd edges, mid-frame size changes, zero sizes) precedes random frames.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import b2y420_pkg::*;

    localparam int LINE_DEPTH   = (MAX_WIDTH_DEFAULT + 1) / 2;
    localparam int IDLE_PCT     = 18;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SAT_SLICE    = 64;

    typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        pixel_t               px;
        bit                   pinned;
        result_t              want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    pixel_t               s_data;
    logic                 m_valid;
    logic                 m_ready;
    result_t              m_data;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    // typed expectation that travels with the current pixel beat
    bit                   pin_check;
    result_t              pin_result;
    bit                   calm = 1'b0;
    int unsigned          fail_count = 0;

    logic [CFG_W-1:0]     model_width  = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0]     model_height = FRAME_HEIGHT_RESET;
    logic                 model_round  = 1'b0;
    int unsigned          col_cnt = 0;
    int unsigned          row_cnt = 0;
    pixel_t               held_px = '0;
    pair_sum_t            sum_line [LINE_DEPTH];
    result_t              pending_yuv [$];
    stim_row_t            directed_rows [$];

    bgra_to_yuv420_converter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned size_limit(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == '0) return 1;
        if (32'(v) > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [7:0] chroma_sat(input int mix);
        int v;
        v = (mix + 32896) >>> 8;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic result_t convert_pixel(input pixel_t px);
        result_t     res;
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int          rnd;
        int          sb;
        int          sg;
        int          sr;
        int          ab;
        int          ag;
        int          ar;
        res = '0;
        w   = size_limit(model_width, MAX_WIDTH_DEFAULT);
        h   = size_limit(model_height, MAX_HEIGHT);
        idx = col_cnt >> 1;
        res.luma = 8'((77 * int'(px.red) + 150 * int'(px.green) + 29 * int'(px.blue) + 128) >>> 8);
        if ((col_cnt & 1) == 0) begin
            held_px = px;
        end else begin
            sb = int'(held_px.blue) + int'(px.blue);
            sg = int'(held_px.green) + int'(px.green);
            sr = int'(held_px.red) + int'(px.red);
            if ((row_cnt & 1) == 0) begin
                sum_line[idx].blue  = 9'(sb);
                sum_line[idx].green = 9'(sg);
                sum_line[idx].red   = 9'(sr);
            end else begin
                rnd = model_round ? 2 : 0;
                ab  = (sb + int'(sum_line[idx].blue) + rnd) >>> 2;
                ag  = (sg + int'(sum_line[idx].green) + rnd) >>> 2;
                ar  = (sr + int'(sum_line[idx].red) + rnd) >>> 2;
                res.cb = chroma_sat(-43 * ar - 85 * ag + 128 * ab);
                res.cr = chroma_sat(128 * ar - 107 * ag - 21 * ab);
                res.chroma_valid = 1'b1;
            end
        end
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt + 1 >= h) begin
                row_cnt = 0;
                res.frame_end = 1'b1;
            end else begin
                row_cnt = row_cnt + 1;
            end
        end else begin
            col_cnt = col_cnt + 1;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t predicted;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  model_width  = cfg_wr_data;
                    CFG_FRAME_HEIGHT: model_height = cfg_wr_data;
                    CFG_AVG_ROUND:    model_round  = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predicted = convert_pixel(s_data);
                pending_yuv.push_back(pin_check ? pin_result : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_yuv.size() == 0) begin
                    $error("result beat with no pixel pending");
                    fail_count++;
                end else begin
                    predicted = pending_yuv.pop_front();
                    check_field("luma", predicted.luma, m_data.luma);
                    check_field("chroma_valid", 8'(predicted.chroma_valid),
                                8'(m_data.chroma_valid));
                    check_field("cb", predicted.cb, m_data.cb);
                    check_field("cr", predicted.cr, m_data.cr);
                    check_field("frame_end", 8'(predicted.frame_end), 8'(m_data.frame_end));
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        stim_row_t row;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_value = val;
        row.px        = '0;
        row.pinned    = 1'b0;
        row.want      = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pixel(input logic [7:0] blue, input logic [7:0] green,
                                      input logic [7:0] red, input bit pinned = 1'b0,
                                      input result_t want = '0);
        stim_row_t row;
        row.kind      = ROW_PIXEL;
        row.reg_index = CFG_FRAME_WIDTH;
        row.reg_value = '0;
        row.px        = {blue, green, red};
        row.pinned    = pinned;
        row.want      = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [7:0] rand_channel();
        if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input pixel_t px, input bit pinned, input result_t want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= px;
        pin_check  <= pinned;
        pin_result <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (pending_yuv.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        int unsigned w_pick;
        int unsigned h_pick;
        int unsigned frame_px;
        int unsigned random_items;
        int unsigned frame_idx;
        int unsigned pick;
        bit          cut_short;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_FRAME_WIDTH;
        cfg_wr_data = '0;
        pin_check   = 1'b0;
        pin_result  = '0;

        // reset-size frame: extremes, then shrink width mid-row and height mid-frame
        add_pixel(8'd0, 8'd0, 8'd0, 1'b1, {8'd0, 1'b0, 8'd0, 8'd0, 1'b0});
        add_pixel(8'd255, 8'd255, 8'd255, 1'b1, {8'd255, 1'b0, 8'd0, 8'd0, 1'b0});
        add_write(CFG_FRAME_WIDTH, 13'd2);
        add_pixel(8'h12, 8'h34, 8'h56);
        add_write(CFG_FRAME_HEIGHT, 13'd1);
        add_pixel(8'hFF, 8'h80, 8'h01);
        add_pixel(8'h7F, 8'h00, 8'hFE);
        // saturated primaries, chroma clamps at the top
        add_write(CFG_FRAME_HEIGHT, 13'd2);
        repeat (3) add_pixel(8'd255, 8'd0, 8'd0);
        add_pixel(8'd255, 8'd0, 8'd0, 1'b1, {8'd29, 1'b1, 8'd255, 8'd107, 1'b1});
        repeat (3) add_pixel(8'd0, 8'd0, 8'd255);
        add_pixel(8'd0, 8'd0, 8'd255, 1'b1, {8'd77, 1'b1, 8'd85, 8'd255, 1'b1});
        add_write(CFG_AVG_ROUND, 13'd1);
        repeat (3) add_pixel(8'd0, 8'd255, 8'd0);
        add_pixel(8'd0, 8'd255, 8'd0, 1'b1, {8'd149, 1'b1, 8'd43, 8'd21, 1'b1});
        // odd last column and odd last row
        add_write(CFG_FRAME_WIDTH, 13'd3);
        add_write(CFG_FRAME_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) add_pixel(8'(i * 29 + 3), 8'(255 - i * 31), 8'(i * 57));
        // zero sizes count as one
        add_write(CFG_FRAME_WIDTH, 13'd0);
        add_write(CFG_FRAME_HEIGHT, 13'd0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b1, {8'd0, 1'b0, 8'd0, 8'd0, 1'b1});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                s_valid <= 1'b0;
                wait_drained();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_pixel(directed_rows[i].px, directed_rows[i].pinned, directed_rows[i].want);
            end
        end

        random_items = 0;
        frame_idx    = 0;
        while (random_items < RANDOM_ITEMS || frame_idx < 12) begin
            calm = (frame_idx >= 8 && frame_idx < 12);
            case (frame_idx)
                2: begin
                    w_pick = 8191;
                    h_pick = 2;
                end
                5: begin
                    w_pick = 1;
                    h_pick = 8191;
                end
                default: begin
                    pick   = $urandom_range(0, 9);
                    w_pick = (pick == 0) ? 0 :
                             (pick == 1) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                    pick   = $urandom_range(0, 19);
                    h_pick = (pick < 2) ? 0 :
                             (pick == 2) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                end
            endcase
            s_valid <= 1'b0;
            wait_drained();
            write_reg(CFG_FRAME_WIDTH, CFG_W'(w_pick));
            write_reg(CFG_FRAME_HEIGHT, CFG_W'(h_pick));
            write_reg(CFG_AVG_ROUND, CFG_W'($urandom_range(0, 1)));
            frame_px = size_limit(CFG_W'(w_pick), MAX_WIDTH_DEFAULT)
                     * size_limit(CFG_W'(h_pick), MAX_HEIGHT);
            cut_short = (frame_idx == 2 || frame_idx == 5);
            if (cut_short) frame_px = SAT_SLICE;
            repeat (frame_px) begin
                // hold the sender until the pipe drains
                if (!calm && $urandom_range(0, 299) == 0) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
                send_pixel({rand_channel(), rand_channel(), rand_channel()}, 1'b0, '0);
            end
            // close a saturated-size frame: shrink to 1 x 1, one beat ends it
            if (cut_short) begin
                s_valid <= 1'b0;
                wait_drained();
                write_reg(CFG_FRAME_WIDTH, CFG_W'(1));
                write_reg(CFG_FRAME_HEIGHT, CFG_W'(1));
                send_pixel({rand_channel(), rand_channel(), rand_channel()}, 1'b0, '0);
            end
            if (frame_idx != 2 && frame_idx != 5) random_items += frame_px;
            frame_idx++;
        end

        s_valid <= 1'b0;
        wait_drained();
        if (fail_count == 0) begin
            $display("bgra_to_yuv420_converter verification clean");
        end else begin
            $display("bgra_to_yuv420_converter verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("bgra_to_yuv420_converter verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/b2y420_pkg.sv
hw/rtl/bgra_to_yuv420_converter.sv
hw/rtl/b2y420_checker.sv
sim/tb_top.sv
